/* rtl/bdph_pkg.sv */
package bdph_pkg;

    localparam int NUM_BUTTONS_DEF = 4;
    localparam int MAX_RESULTS     = 4;
    localparam int IN_W            = 4;
    localparam int CNT_W           = 8;
    localparam int DUR_W           = 16;
    localparam int WR_DATA_W       = 16;
    localparam int WR_INDEX_W      = 2;

    localparam logic [CNT_W-1:0] DEBOUNCE_RST = 8'd10;
    localparam logic [DUR_W-1:0] HOLD_RST     = 16'd1000;
    localparam logic [IN_W-1:0]  MASK_RST     = 4'hF;
    localparam logic             HOLD_EN_RST  = 1'b1;

    typedef enum logic [1:0] {
        ACT_PRESS   = 2'd0,
        ACT_RELEASE = 2'd1,
        ACT_HOLD    = 2'd2
    } action_t;

    typedef enum logic [WR_INDEX_W-1:0] {
        REG_DEBOUNCE = 2'd0,
        REG_HOLD     = 2'd1,
        REG_MASK     = 2'd2,
        REG_HOLD_EN  = 2'd3
    } reg_index_t;

    typedef struct packed {
        logic [CNT_W-1:0] debounce_ms;
        logic [DUR_W-1:0] hold_ms;
        logic             hold_enable;
    } btn_cfg_t;

    typedef struct packed {
        logic             valid;
        action_t          action;
        logic [DUR_W-1:0] duration;
    } btn_event_t;

endpackage

/* rtl/bdph_button.sv */
module bdph_button
    import bdph_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       tick,
    input  logic       level,
    input  btn_cfg_t   cfg,
    output btn_event_t evt
);

    logic             last_reg, last_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             acc_reg, acc_next;
    logic [DUR_W-1:0] elapsed_reg, elapsed_next;
    logic             fired_reg, fired_next;

    always_comb
    begin
        last_next    = last_reg;
        count_next   = count_reg;
        acc_next     = acc_reg;
        fired_next   = fired_reg;
        evt          = '0;
        evt.action   = ACT_PRESS;

        elapsed_next = elapsed_reg;
        if (acc_reg && (elapsed_reg != '1))
        begin
            elapsed_next = elapsed_reg + 1'b1;
        end

        if (level != last_reg)
        begin
            last_next  = level;
            count_next = '0;
        end
        else if (count_reg != '1)
        begin
            count_next = count_reg + 1'b1;
        end

        if (count_next >= cfg.debounce_ms)
        begin
            if (level != acc_reg)
            begin
                acc_next  = level;
                evt.valid = 1'b1;
                if (level)
                begin
                    elapsed_next = '0;
                    evt.action   = ACT_PRESS;
                    evt.duration = '0;
                end
                else
                begin
                    fired_next   = 1'b0;
                    evt.action   = ACT_RELEASE;
                    evt.duration = elapsed_next;
                end
            end

            // A fresh press clears the elapsed time, so a hold can never
            // coincide with a press or release event of the same tick.
            if (acc_next && cfg.hold_enable && !fired_next && (elapsed_next > cfg.hold_ms))
            begin
                fired_next   = 1'b1;
                evt.valid    = 1'b1;
                evt.action   = ACT_HOLD;
                evt.duration = elapsed_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_reg    <= 1'b0;
            count_reg   <= '0;
            acc_reg     <= 1'b0;
            elapsed_reg <= '0;
            fired_reg   <= 1'b0;
        end
        else if (tick)
        begin
            last_reg    <= last_next;
            count_reg   <= count_next;
            acc_reg     <= acc_next;
            elapsed_reg <= elapsed_next;
            fired_reg   <= fired_next;
        end
    end

endmodule

/* rtl/button_debounce_press_hold.sv */
// Button debouncer with press, release and hold events.
// Input channel (in_valid/in_ready, raw_levels): one item per millisecond
// tick carrying the raw pin level of every button. Output channel
// (out_valid/out_ready): one item per event, with button_index, action
// (press, release, hold), duration_ms and last_event marking the final
// event of a tick. Events of one tick leave in ascending button order.
// Flow: the events of an accepted tick are first captured in the pending
// registers, then move one at a time into the single output register. A tick
// with no events leaves nothing pending, so such ticks can be accepted every
// cycle while nothing is pending. The next tick is accepted in the cycle the
// last pending event of the current tick moves into the output register.
// When the receiver stalls, the output register holds its event and
// the pending events of the tick wait, and then input is refused.
// Configuration: wr_en/wr_index/wr_data write a configuration register.
// Reset restores the default configuration and clears all button state,
// pending events and the valid flag of the output register.
module button_debounce_press_hold
    import bdph_pkg::*;
#(
    parameter int NUM_BUTTONS = NUM_BUTTONS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [IN_W-1:0]       raw_levels,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [1:0]            button_index,
    output logic [1:0]            action,
    output logic [DUR_W-1:0]      duration_ms,
    output logic                  last_event,
    input  logic                  wr_en,
    input  logic [WR_INDEX_W-1:0] wr_index,
    input  logic [WR_DATA_W-1:0]  wr_data
);

    localparam int IDX_W = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;

    // Configuration registers
    logic [CNT_W-1:0] debounce_reg;
    logic [DUR_W-1:0] hold_reg;
    logic [IN_W-1:0]  mask_reg;
    logic             hold_en_reg;
    btn_cfg_t         cfg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg <= DEBOUNCE_RST;
            hold_reg     <= HOLD_RST;
            mask_reg     <= MASK_RST;
            hold_en_reg  <= HOLD_EN_RST;
        end
        else if (wr_en)
        begin
            case (reg_index_t'(wr_index))
                REG_DEBOUNCE: debounce_reg <= wr_data[CNT_W-1:0];
                REG_HOLD:     hold_reg     <= wr_data[DUR_W-1:0];
                REG_MASK:     mask_reg     <= wr_data[IN_W-1:0];
                REG_HOLD_EN:  hold_en_reg  <= wr_data[0];
                default:      ;
            endcase
        end
    end

    assign cfg.debounce_ms = debounce_reg;
    assign cfg.hold_ms     = hold_reg;
    assign cfg.hold_enable = hold_en_reg;

    // Per-button debounce cells
    logic                   accept;
    logic [NUM_BUTTONS-1:0] level;
    btn_event_t             evt [NUM_BUTTONS];

    for (genvar g = 0; g < NUM_BUTTONS; g++)
    begin : g_btn
        if (g < IN_W)
        begin : g_pin
            assign level[g] = raw_levels[g] ^ mask_reg[g];
        end
        else
        begin : g_nopin
            assign level[g] = 1'b0;
        end

        bdph_button u_button (
            .clk   (clk),
            .rst_n (rst_n),
            .tick  (accept),
            .level (level[g]),
            .cfg   (cfg),
            .evt   (evt[g])
        );
    end

    // Only the first MAX_RESULTS events of a tick are kept.
    logic [NUM_BUTTONS-1:0] keep_mask;
    logic [2:0]             keep_cnt;

    always_comb
    begin
        keep_mask = '0;
        keep_cnt  = '0;
        for (int i = 0; i < NUM_BUTTONS; i++)
        begin
            if (evt[i].valid && (keep_cnt < 3'(MAX_RESULTS)))
            begin
                keep_mask[i] = 1'b1;
                keep_cnt     = keep_cnt + 1'b1;
            end
        end
    end

    // Pending events of the current tick
    logic [NUM_BUTTONS-1:0] pend_mask_reg, pend_mask_next;
    action_t                pend_act_reg [NUM_BUTTONS];
    logic [DUR_W-1:0]       pend_dur_reg [NUM_BUTTONS];
    logic [NUM_BUTTONS-1:0] rest_mask;
    logic [IDX_W-1:0]       sel_idx;
    logic                   pend_any;
    logic                   move;

    always_comb
    begin
        sel_idx = '0;
        for (int i = NUM_BUTTONS - 1; i >= 0; i--)
        begin
            if (pend_mask_reg[i])
            begin
                sel_idx = IDX_W'(i);
            end
        end
    end

    assign rest_mask = pend_mask_reg & (pend_mask_reg - 1'b1);
    assign pend_any  = |pend_mask_reg;
    assign move      = pend_any && (!out_valid || out_ready);
    assign in_ready  = !pend_any || (move && (rest_mask == '0));
    assign accept    = in_valid && in_ready;

    always_comb
    begin
        pend_mask_next = pend_mask_reg;
        if (accept)
        begin
            pend_mask_next = keep_mask;
        end
        else if (move)
        begin
            pend_mask_next = rest_mask;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_mask_reg <= '0;
        end
        else
        begin
            pend_mask_reg <= pend_mask_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int i = 0; i < NUM_BUTTONS; i++)
            begin
                pend_act_reg[i] <= evt[i].action;
                pend_dur_reg[i] <= evt[i].duration;
            end
        end
    end

    // Output register
    logic             out_valid_reg;
    logic [1:0]       index_reg;
    action_t          action_reg;
    logic [DUR_W-1:0] dur_reg;
    logic             last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (move)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (move)
        begin
            index_reg  <= 2'(sel_idx);
            action_reg <= pend_act_reg[sel_idx];
            dur_reg    <= pend_dur_reg[sel_idx];
            last_reg   <= (rest_mask == '0);
        end
    end

    assign out_valid    = out_valid_reg;
    assign button_index = index_reg;
    assign action       = action_reg;
    assign duration_ms  = dur_reg;
    assign last_event   = last_reg;

`ifndef SYNTHESIS
    a_keep_limit: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> ($countones(pend_mask_reg) <= MAX_RESULTS))
        else $error("more events pending than one tick may produce");

    a_pend_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (pend_any && !move) |=> $stable(pend_mask_reg))
        else $error("pending events changed without moving to the output");

    a_burst: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_ready && !last_reg) |=> out_valid_reg)
        else $error("gap inside the events of one tick");
`endif

endmodule

/* bench/button_debounce_press_hold_tb.sv */
`timescale 1ns / 100ps

module button_debounce_press_hold_tb;
    import bdph_pkg::*;

    localparam int NB = NUM_BUTTONS_DEF;
    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int SETTLE_CYCLES = 8;

    typedef struct {
        logic [1:0]       button;
        action_t          act;
        logic [DUR_W-1:0] dur;
        logic             last;
    } btn_evt_t;

    logic                  clk;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic [IN_W-1:0]       raw_levels = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [1:0]            button_index;
    logic [1:0]            action;
    logic [DUR_W-1:0]      duration_ms;
    logic                  last_event;
    logic                  wr_en = 1'b0;
    logic [WR_INDEX_W-1:0] wr_index = '0;
    logic [WR_DATA_W-1:0]  wr_data = '0;

    // Configuration as the block should currently see it.
    logic [CNT_W-1:0] cfg_debounce = DEBOUNCE_RST;
    logic [DUR_W-1:0] cfg_hold     = HOLD_RST;
    logic [IN_W-1:0]  cfg_mask     = MASK_RST;
    logic             cfg_hold_en  = HOLD_EN_RST;

    // Per-button debounce state of the predictor.
    logic [NB-1:0]    prev_level  = '0;
    logic [NB-1:0]    acc_pressed = '0;
    logic [NB-1:0]    hold_done   = '0;
    logic [CNT_W-1:0] stable_ticks [NB];
    logic [DUR_W-1:0] held_ms [NB];

    logic [IN_W-1:0] pending_ticks [$];
    btn_evt_t        expected_events [$];
    btn_evt_t        exp_ev;
    logic [IN_W-1:0] gesture_level = '0;

    logic steady = 1'b0;
    int   gap_left = 0;
    int   stall_left = 0;
    int   cycles = 0;
    int   errors = 0;
    int   ticks_sent = 0;
    int   events_checked = 0;
    int   press_seen = 0;
    int   release_seen = 0;
    int   hold_seen = 0;
    int   settings_used = 0;

    button_debounce_press_hold dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .raw_levels   (raw_levels),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .button_index (button_index),
        .action       (action),
        .duration_ms  (duration_ms),
        .last_event   (last_event),
        .wr_en        (wr_en),
        .wr_index     (wr_index),
        .wr_data      (wr_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Advances every button by one millisecond tick and queues the events
    // the block must emit for it, in ascending button order.
    task automatic predict_events(input logic [IN_W-1:0] raw);
        btn_evt_t evs [$];
        btn_evt_t ev;
        logic     level;
        int       b;
        for (b = 0; b < NB; b++)
        begin
            level = raw[b] ^ cfg_mask[b];
            if (acc_pressed[b] && held_ms[b] != '1)
                held_ms[b]++;
            if (level != prev_level[b])
            begin
                prev_level[b] = level;
                stable_ticks[b] = '0;
            end
            else if (stable_ticks[b] != '1)
            begin
                stable_ticks[b]++;
            end
            if (stable_ticks[b] >= cfg_debounce)
            begin
                ev.button = 2'(b);
                ev.last = 1'b0;
                if (level != acc_pressed[b])
                begin
                    acc_pressed[b] = level;
                    if (level)
                    begin
                        held_ms[b] = '0;
                        ev.act = ACT_PRESS;
                        ev.dur = '0;
                    end
                    else
                    begin
                        hold_done[b] = 1'b0;
                        ev.act = ACT_RELEASE;
                        ev.dur = held_ms[b];
                    end
                    evs.push_back(ev);
                end
                if (acc_pressed[b] && cfg_hold_en && !hold_done[b] && held_ms[b] > cfg_hold)
                begin
                    hold_done[b] = 1'b1;
                    ev.act = ACT_HOLD;
                    ev.dur = held_ms[b];
                    evs.push_back(ev);
                end
            end
        end
        if (evs.size() != 0)
            evs[evs.size() - 1].last = 1'b1;
        foreach (evs[i])
            expected_events.push_back(evs[i]);
    endtask

    function automatic int pick_idle();
        int r;
        r = $urandom_range(0, 99);
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Sender: one tick per handshake, with random gaps between ticks.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            gap_left <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                predict_events(raw_levels);
                ticks_sent++;
            end
            if (in_valid && !in_ready)
            begin
                // The current item stays on the port until it is taken.
            end
            else if (gap_left != 0)
            begin
                in_valid <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (pending_ticks.size() != 0)
            begin
                in_valid <= 1'b1;
                raw_levels <= pending_ticks.pop_front();
                gap_left <= (steady || $urandom_range(0, 1)) ? 0 : pick_idle();
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, none while a steady phase runs.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            stall_left <= 0;
        end
        else if (steady)
        begin
            out_ready <= 1'b1;
        end
        else if (stall_left != 0)
        begin
            out_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if ($urandom_range(0, 3) == 0)
        begin
            out_ready <= 1'b0;
            stall_left <= pick_idle() - 1;
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_events.size() == 0)
            begin
                $error("unexpected event: button %0d action %0d duration %0d last %0d",
                       button_index, action, duration_ms, last_event);
                errors++;
            end
            else
            begin
                exp_ev = expected_events.pop_front();
                events_checked++;
                case (exp_ev.act)
                    ACT_PRESS:   press_seen++;
                    ACT_RELEASE: release_seen++;
                    default:     hold_seen++;
                endcase
                if (button_index !== exp_ev.button)
                begin
                    $error("button_index: expected %0d, got %0d", exp_ev.button, button_index);
                    errors++;
                end
                if (action !== exp_ev.act)
                begin
                    $error("action: expected %0d, got %0d", exp_ev.act, action);
                    errors++;
                end
                if (duration_ms !== exp_ev.dur)
                begin
                    $error("duration_ms: expected %0d, got %0d", exp_ev.dur, duration_ms);
                    errors++;
                end
                if (last_event !== exp_ev.last)
                begin
                    $error("last_event: expected %0d, got %0d", exp_ev.last, last_event);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d events still expected",
                     cycles, expected_events.size());
            $display("button_debounce_press_hold verification failed");
            $finish;
        end
    end

    task automatic write_reg(input reg_index_t idx, input logic [WR_DATA_W-1:0] val);
        @(posedge clk);
        wr_en <= 1'b1;
        wr_index <= idx;
        wr_data <= val;
        @(posedge clk);
        wr_en <= 1'b0;
        case (idx)
            REG_DEBOUNCE: cfg_debounce = val[CNT_W-1:0];
            REG_HOLD:     cfg_hold = val[DUR_W-1:0];
            REG_MASK:     cfg_mask = val[IN_W-1:0];
            REG_HOLD_EN:  cfg_hold_en = val[0];
            default:      ;
        endcase
    endtask

    task automatic push_ticks(input logic [IN_W-1:0] raw, input int n);
        repeat (n) pending_ticks.push_back(raw);
    endtask

    // Returns once every tick is taken and every event has arrived, then lets a
    // settle period run out for ticks that produce nothing but may still be in flight.
    task automatic wait_for_quiet();
        while (pending_ticks.size() != 0 || in_valid || expected_events.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Button gestures in pressed-level terms: mostly clean presses and
    // releases with a little contact bounce, plus glitches and raw noise.
    task automatic queue_gestures(input int count);
        int              sent;
        int              r;
        int              n;
        int              k;
        logic [IN_W-1:0] flips;
        logic [IN_W-1:0] target;
        sent = 0;
        while (sent < count)
        begin
            r = $urandom_range(0, 9);
            if (r == 0)
            begin
                n = $urandom_range(1, 4);
                repeat (n) pending_ticks.push_back(IN_W'($urandom_range(0, 15)));
                sent += n;
            end
            else if (r == 1)
            begin
                // A one-tick glitch on a button, then the old levels again.
                flips = IN_W'(1 << $urandom_range(0, IN_W - 1));
                pending_ticks.push_back((gesture_level ^ flips) ^ cfg_mask);
                n = cfg_debounce + $urandom_range(0, cfg_hold + 2);
                push_ticks(gesture_level ^ cfg_mask, n);
                sent += n + 1;
            end
            else
            begin
                flips = IN_W'($urandom_range(1, 15));
                target = gesture_level ^ flips;
                k = $urandom_range(0, 3);
                repeat (k) pending_ticks.push_back((gesture_level ^ (flips & IN_W'($urandom)))
                                                   ^ cfg_mask);
                if ($urandom_range(0, 6) == 0)
                    n = $urandom_range(1, cfg_debounce + 1);
                else
                    n = cfg_debounce + $urandom_range(1, cfg_hold + 4);
                push_ticks(target ^ cfg_mask, n);
                gesture_level = target;
                sent += k + n;
            end
        end
    endtask

    initial
    begin
        for (int b = 0; b < NB; b++)
        begin
            stable_ticks[b] = '0;
            held_ms[b] = '0;
        end
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Reset configuration: all four buttons pressed and released at once.
        settings_used++;
        push_ticks(4'h0, 11);
        push_ticks(4'hF, 11);
        wait_for_quiet();

        // No debounce, hold right after the press, active-high buttons.
        settings_used++;
        write_reg(REG_DEBOUNCE, 16'd0);
        write_reg(REG_HOLD, 16'd0);
        write_reg(REG_MASK, 16'h0000);
        write_reg(REG_HOLD_EN, 16'd1);
        push_ticks(4'b0001, 2);
        push_ticks(4'b1111, 1);
        push_ticks(4'b1110, 1);
        push_ticks(4'b0000, 1);
        push_ticks(4'b1010, 1);
        push_ticks(4'b0101, 1);
        gesture_level = 4'b0101;
        queue_gestures(40);
        wait_for_quiet();

        settings_used++;
        write_reg(REG_DEBOUNCE, 16'd3);
        write_reg(REG_HOLD, 16'd8);
        write_reg(REG_MASK, 16'h000A);
        queue_gestures(60);
        wait_for_quiet();

        // Hold events off; releases must still re-arm them.
        settings_used++;
        write_reg(REG_DEBOUNCE, 16'd1);
        write_reg(REG_HOLD, 16'd5);
        write_reg(REG_MASK, 16'h0005);
        write_reg(REG_HOLD_EN, 16'd0);
        queue_gestures(50);
        wait_for_quiet();

        settings_used++;
        steady = 1'b1;
        write_reg(REG_DEBOUNCE, 16'd5);
        write_reg(REG_HOLD, 16'd20);
        write_reg(REG_MASK, 16'h000F);
        write_reg(REG_HOLD_EN, 16'd1);
        queue_gestures(50);
        wait_for_quiet();

        // Longer debounce time, with a short bounce in the middle.
        settings_used++;
        write_reg(REG_DEBOUNCE, 16'd12);
        write_reg(REG_HOLD, 16'd4);
        write_reg(REG_MASK, 16'h0000);
        push_ticks(4'hF, 14);
        push_ticks(4'h5, 2);
        push_ticks(4'hF, 14);
        push_ticks(4'h0, 14);
        wait_for_quiet();

        settings_used++;
        steady = 1'b0;
        write_reg(REG_DEBOUNCE, 16'($urandom_range(1, 4)));
        write_reg(REG_HOLD, 16'($urandom_range(0, 15)));
        write_reg(REG_MASK, 16'($urandom_range(0, 15)));
        write_reg(REG_HOLD_EN, 16'($urandom_range(0, 1)));
        gesture_level = '0;
        queue_gestures(30);
        wait_for_quiet();

        repeat (20) @(posedge clk);
        $display("%0d ticks across %0d register settings, with and without output stalls",
                 ticks_sent, settings_used);
        $display("%0d events checked: %0d press, %0d release, %0d hold",
                 events_checked, press_seen, release_seen, hold_seen);
        if (errors == 0)
            $display("button_debounce_press_hold verification clean");
        else
            $display("button_debounce_press_hold verification failed");
        $finish;
    end

endmodule

/* files.f */
rtl/bdph_pkg.sv
rtl/bdph_button.sv
rtl/button_debounce_press_hold.sv
bench/button_debounce_press_hold_tb.sv
